### hdl/upd_pkg.sv
// upd_pkg: shared types, character constants and digit helpers for the url percent decoder
// used by upd_front, upd_queue, upd_back and the top level; no dependencies
package upd_pkg;

  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_PERCENT = 8'h25;
  localparam logic [7:0] CHR_SPACE   = 8'h20;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_LA      = 8'h61;
  localparam logic [7:0] CHR_LF      = 8'h66;
  localparam logic [7:0] CHR_UA      = 8'h41;
  localparam logic [7:0] CHR_UF      = 8'h46;
  localparam logic [7:0] LA_OFFSET   = CHR_LA - 8'd10;
  localparam logic [7:0] UA_OFFSET   = CHR_UA - 8'd10;

  typedef enum logic [1:0] {
    OP_PLAIN = 2'd0,  // one result: byte with plus mapped to space
    OP_HEX   = 2'd1,  // one result: two digits combined
    OP_TAIL  = 2'd2   // two results: percent, then plain byte as last
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] held;
    logic [7:0] data;
    logic       last;
  } upd_op_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      v = c - CHR_ZERO;
    end else if (c >= CHR_LA && c <= CHR_LF) begin
      v = c - LA_OFFSET;
    end else if (c >= CHR_UA && c <= CHR_UF) begin
      v = c - UA_OFFSET;
    end else begin
      v = c;
    end
    return v;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CHR_PLUS) ? CHR_SPACE : c;
  endfunction

endpackage

### hdl/upd_front.sv
// upd_front: accepts input bytes, tracks the escape phase and queues one op per result group
// depends on upd_pkg
module upd_front import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       op_push_o,
  output upd_op_t    op_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PCT   = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    op_push_o  = 1'b0;
    op_o.kind  = OP_PLAIN;
    op_o.held  = held_q;
    op_o.data  = in_byte_i;
    op_o.last  = in_last_i;
    if (accept_i) begin
      unique case (phase_q)
        PH_PCT: begin
          if (in_last_i) begin
            op_push_o = 1'b1;
            op_o.kind = OP_TAIL;
            phase_d   = PH_IDLE;
          end else begin
            held_d  = in_byte_i;
            phase_d = PH_DIGIT;
          end
        end
        PH_DIGIT: begin
          op_push_o = 1'b1;
          op_o.kind = OP_HEX;
          phase_d   = PH_IDLE;
        end
        default: begin
          // idle, and the unused phase code behaves as idle
          if (in_byte_i == CHR_PERCENT && !in_last_i) begin
            phase_d = PH_PCT;
          end else begin
            op_push_o = 1'b1;
            phase_d   = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

### hdl/upd_queue.sv
// upd_queue: small register queue of decoded ops between front and back
// depends on upd_pkg
module upd_queue import upd_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  upd_op_t wr_op_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    avail_o,
  output upd_op_t rd_op_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  upd_op_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == DepthCnt);
  assign avail_o = (cnt_q != '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && avail_o;
  assign rd_op_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastIdx) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastIdx) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### hdl/upd_back.sv
// upd_back: executes queued ops and holds the result register, including the second tail result
// depends on upd_pkg
module upd_back import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       op_avail_i,
  input  upd_op_t    op_i,
  output logic       op_take_o,
  input  logic       pop_i,
  output logic       valid_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic       valid_q, valid_d;
  logic       pend_q, pend_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       slot_free;
  logic [7:0] hi_val;
  logic [7:0] lo_val;
  logic [7:0] hex_val;

  assign slot_free = !valid_q || pop_i;
  assign hi_val    = digit_value(op_i.held);
  assign lo_val    = digit_value(op_i.data);
  assign hex_val   = {hi_val[3:0], 4'h0} + lo_val;

  always_comb begin
    valid_d     = valid_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    byte_d      = byte_q;
    last_d      = last_q;
    op_take_o   = 1'b0;
    if (slot_free) begin
      priority if (pend_q) begin
        valid_d = 1'b1;
        byte_d  = pend_byte_q;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (op_avail_i) begin
        op_take_o = 1'b1;
        valid_d   = 1'b1;
        unique case (op_i.kind)
          OP_HEX: begin
            byte_d = hex_val;
            last_d = op_i.last;
          end
          OP_TAIL: begin
            byte_d      = CHR_PERCENT;
            last_d      = 1'b0;
            pend_d      = 1'b1;
            pend_byte_d = plain_byte(op_i.data);
          end
          default: begin
            byte_d = plain_byte(op_i.data);
            last_d = op_i.last;
          end
        endcase
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    byte_q      <= byte_d;
    last_q      <= last_d;
  end

  assign valid_o    = valid_q;
  assign out_byte_o = byte_q;
  assign out_last_o = last_q;

endmodule

### hdl/url_percent_decoder_unit.sv
// url_percent_decoder_unit: top level of the streaming url percent decoder
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
// Decodes a percent-encoded url string streamed in one byte per transaction, with in_last_i
// on the final byte. A plus becomes a space, a percent sign and the two bytes after it become
// one byte (16 * high digit + low digit, mod 256, where a non-hex byte counts as its raw code),
// and everything else passes unchanged. A percent sign too close to the end of the string is
// emitted as is, and the one byte after it (if any) goes through the normal plus rule.
// Input side looks like a queue (push / full), result side like a queue (empty / pop).
// Throughput is one input byte per clock while full is low: the front end classifies each byte
// in the cycle it is accepted and the back end produces one result per cycle while the output
// is not stalled. The only case that yields two results from one byte (percent followed by a
// final byte) holds the back end for an extra result; the op queue between front and back
// (QueueDepth entries) absorbs it, so full only rises if such tails or output stalls pile up.
// A result passes through the op queue and the result register before it reaches the ports.
module url_percent_decoder_unit import upd_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input transaction
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  // result transaction
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic    accept;
  logic    op_push;
  upd_op_t op_in;
  logic    q_full;
  logic    q_avail;
  logic    op_take;
  upd_op_t op_out;
  logic    res_valid;

  // the front end owns the escape state, so it only stalls on a full op queue
  assign full   = q_full;
  assign accept = push && !q_full;

  upd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .op_push_o (op_push),
    .op_o      (op_in)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (op_push),
    .wr_op_i (op_in),
    .full_o  (q_full),
    .rd_i    (op_take),
    .avail_o (q_avail),
    .rd_op_o (op_out)
  );

  // back end holds the visible result register plus the pending second tail byte
  upd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_avail_i (q_avail),
    .op_i       (op_out),
    .op_take_o  (op_take),
    .pop_i      (pop),
    .valid_o    (res_valid),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  assign empty = !res_valid;

endmodule

### hdl/upd_checker.sv
// upd_checker: port-level assertions for url_percent_decoder_unit, with its bind statement
// depends on url_percent_decoder_unit ports only
module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // no result shown while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result visible during reset");

  // input side open while in reset
  a_reset_not_full: assert property (@(posedge clk_i) !rst_ni |-> !full)
    else $error("full during reset");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(out_last_o)))
    else $error("waiting result changed or vanished");

  // when reset has just released, nothing is visible yet
  a_first_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
    else $error("result visible right after reset");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (.*);
